[sv/fltpm_pkg.sv]
// Shared types and constants for the four-level page table mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package fltpm_pkg;
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = 9;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int ADDR_W      = SLOT_W + IDX_W;

  localparam logic [1:0] OP_MAP_4K = 2'd0;
  localparam logic [1:0] OP_MAP_2M = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_MAPPED  = 2'd0;
  localparam logic [1:0] ST_ALREADY = 2'd1;
  localparam logic [1:0] ST_NO_MEM  = 2'd2;

  localparam logic [1:0] REG_HEAP_START = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] REG_DIR_BYTES  = 2'd2;
  localparam logic [1:0] REG_LEAF_BYTES = 2'd3;

  localparam logic [63:0] BIT_PRESENT = 64'h1;
  localparam logic [63:0] BIT_LARGE   = 64'h80;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [35:0] virt_page;
    logic [39:0] phys_frame;
    logic        kernel_only;
    logic        writeable;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_written;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] link;
    logic [63:0]      entry;
  } mem_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] base;
    logic [31:0] end_addr;
  } alloc_t;
endpackage
`default_nettype wire

[sv/fltpm_store.sv]
// Table store: one synchronous single-port memory of entries and child links.
// Depends on fltpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fltpm_store (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic                    re,
  input  wire logic [fltpm_pkg::ADDR_W-1:0] addr,
  input  wire fltpm_pkg::mem_word_t    wdata,
  output fltpm_pkg::mem_word_t         rdata
);
  import fltpm_pkg::*;

  mem_word_t mem [TABLE_SLOTS * (1 << IDX_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

[sv/fltpm_alloc.sv]
// Bump allocator check: align to 4 KiB, add table size, test limit and slots.
// Depends on fltpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fltpm_alloc (
  input  wire logic [31:0]               heap_ptr,
  input  wire logic [16:0]               bytes,
  input  wire logic [31:0]               heap_limit,
  input  wire logic [fltpm_pkg::CNT_W-1:0] slots_used,
  output fltpm_pkg::alloc_t              res
);
  import fltpm_pkg::*;

  logic [32:0] aligned;
  logic [33:0] end_full;

  always_comb begin
    aligned  = ({1'b0, heap_ptr} + 33'hFFF) & ~33'hFFF;
    end_full = {1'b0, aligned} + {17'b0, bytes};
    res.ok       = (slots_used < CNT_W'(TABLE_SLOTS)) && (end_full < {2'b0, heap_limit});
    res.base     = aligned[31:0];
    res.end_addr = end_full[31:0];
  end
endmodule
`default_nettype wire

[sv/four_level_page_table_mapper_core.sv]
// Top level of the four-level page table mapper: control sequencer, config
// registers, allocator state. Depends on fltpm_pkg, fltpm_store, fltpm_alloc.
//
// Usage:
//   Raise start with a command word on in_word while busy is low; the word is
//   taken at that edge. Exactly one result word appears on out_word with
//   out_valid high for one cycle; the receiver cannot stall it, so it must
//   take it then. A new command may be given in the cycle the result shows.
// Sequence (accept edge to out_valid):
//   unused opcode or map with no root: out_valid is high in the next cycle.
//   map: a read state, then a check/write state, per table level visited;
//   each step waits on the single store port's read.
//   clear: one store entry zeroed per cycle over all TABLE_SLOTS*512 (8192)
//   entries, then the root is allocated in S_ROOT.
// Configuration: cfg_we/cfg_index/cfg_wdata write a register at once; write
//   only while busy is low.
// Reset: config takes its defaults, no root exists, the heap rewinds. The
//   store is not cleared by reset; it is only read after a clear sweep.
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_mapper_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire fltpm_pkg::in_word_t in_word,
  output logic               out_valid,
  output fltpm_pkg::out_word_t out_word,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_wdata
);
  import fltpm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_ROOT  = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      heap_start_r, heap_limit_r;
  logic [16:0]      dir_bytes_r, leaf_bytes_r;
  logic [31:0]      hp_r, hp_nxt;
  logic [CNT_W-1:0] slots_r, slots_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [1:0]       level_r, level_nxt;
  logic [SLOT_W-1:0] tbl_r, tbl_nxt;
  in_word_t         cmd_r, cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  mem_word_t        mem_wdata, mem_rdata;
  logic [31:0]      al_ptr;
  logic [16:0]      al_bytes;
  logic [CNT_W-1:0] al_slots;
  alloc_t           al;
  logic [IDX_W-1:0] idx;
  logic [63:0]      flags, leaf_4k, leaf_2m;
  logic             descend;

  fltpm_store u_store (
    .clk(clk), .we(mem_we), .re(mem_re), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  fltpm_alloc u_alloc (
    .heap_ptr(al_ptr), .bytes(al_bytes), .heap_limit(heap_limit_r),
    .slots_used(al_slots), .res(al)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Pick the 9-bit index of the current level, root first.
  always_comb begin
    case (level_r)
      2'd0:    idx = cmd_r.virt_page[35:27];
      2'd1:    idx = cmd_r.virt_page[26:18];
      2'd2:    idx = cmd_r.virt_page[17:9];
      default: idx = cmd_r.virt_page[8:0];
    endcase
  end

  assign flags   = {61'b0, ~cmd_r.kernel_only, cmd_r.writeable, 1'b0} | BIT_PRESENT;
  assign leaf_4k = {12'b0, cmd_r.phys_frame, 12'b0} | flags;
  assign leaf_2m = {12'b0, cmd_r.phys_frame[39:9], 21'b0} | flags | BIT_LARGE;
  // Walk through this entry to a child table, rather than write a leaf.
  assign descend = (level_r < 2'd2) || (level_r == 2'd2 && cmd_r.opcode == OP_MAP_4K);

  // Root allocation starts from heap_start with no slots in use.
  always_comb begin
    if (state_r == S_ROOT) begin
      al_ptr   = heap_start_r;
      al_slots = '0;
      al_bytes = dir_bytes_r;
    end else begin
      al_ptr   = hp_r;
      al_slots = slots_r;
      al_bytes = (level_r == 2'd2) ? leaf_bytes_r : dir_bytes_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hp_nxt        = hp_r;
    slots_nxt     = slots_r;
    sweep_nxt     = sweep_r;
    level_nxt     = level_r;
    tbl_nxt       = tbl_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = {tbl_r, idx};
    mem_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_word;
          level_nxt = 2'd0;
          tbl_nxt   = '0;
          out_nxt   = '0;
          if (in_word.opcode == OP_CLEAR) begin
            sweep_nxt = '0;
            state_nxt = S_SWEEP;
          end else if (in_word.opcode != OP_MAP_4K && in_word.opcode != OP_MAP_2M) begin
            out_valid_nxt = 1'b1;
          end else if (slots_r == '0) begin
            out_nxt.status = ST_NO_MEM;
            out_valid_nxt  = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SWEEP: begin
        // Zero one entry per cycle.
        mem_we    = 1'b1;
        mem_addr  = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        hp_nxt        = al.ok ? al.end_addr : heap_start_r;
        slots_nxt     = al.ok ? CNT_W'(1) : '0;
        out_nxt       = '0;
        out_nxt.status = al.ok ? ST_MAPPED : ST_NO_MEM;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (descend) begin
          if (mem_rdata.link != '0) begin
            tbl_nxt   = SLOT_W'(mem_rdata.link - 1'b1);
            level_nxt = level_r + 2'd1;
            state_nxt = S_READ;
          end else if (al.ok) begin
            // Link a fresh table at the next free slot.
            mem_we          = 1'b1;
            mem_wdata.entry = {32'b0, al.base} | flags;
            mem_wdata.link  = slots_r + 1'b1;
            hp_nxt          = al.end_addr;
            slots_nxt       = slots_r + 1'b1;
            tbl_nxt         = SLOT_W'(slots_r);
            level_nxt       = level_r + 2'd1;
            state_nxt       = S_READ;
          end else begin
            out_nxt.status = ST_NO_MEM;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (level_r == 2'd2) begin
          // Large page: overwrite entry, keep any child link.
          mem_we              = 1'b1;
          mem_wdata.entry     = leaf_2m;
          mem_wdata.link      = mem_rdata.link;
          out_nxt.entry_written = leaf_2m;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          if (mem_rdata.entry != '0) begin
            out_nxt.status = ST_ALREADY;
          end else begin
            mem_we                = 1'b1;
            mem_wdata.entry       = leaf_4k;
            mem_wdata.link        = mem_rdata.link;
            out_nxt.entry_written = leaf_4k;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_start_r <= 32'd1048576;
      heap_limit_r <= 32'd16777216;
      dir_bytes_r  <= 17'd12288;
      leaf_bytes_r <= 17'd4096;
      hp_r         <= 32'd1048576;
      slots_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hp_r        <= hp_nxt;
      slots_r     <= slots_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_START: heap_start_r <= cfg_wdata;
          REG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
          REG_DIR_BYTES:  dir_bytes_r  <= cfg_wdata[16:0];
          REG_LEAF_BYTES: leaf_bytes_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    sweep_r <= sweep_nxt;
    level_r <= level_nxt;
    tbl_r   <= tbl_nxt;
    cmd_r   <= cmd_nxt;
    out_r   <= out_nxt;
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_r <= CNT_W'(TABLE_SLOTS)) else $error("slot count past table slots");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE)) else $error("store write while idle");
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("accepted word dropped");
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy || start)) else $error("result with no command");
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for four_level_page_table_mapper_core.
// Depends on fltpm_pkg; predicts every result word with a local page-table model.
`timescale 1ns / 1ps
module tb_top;
  import fltpm_pkg::*;

  localparam int ENTRIES  = 512;
  localparam int DEPTH    = TABLE_SLOTS * ENTRIES;
  localparam int N_RANDOM = 1430;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  four_level_page_table_mapper_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Local copy of the configuration and of the table store.
  logic [31:0] heap_start_r, heap_limit_r, dir_bytes_r, leaf_bytes_r;
  logic [63:0] table_mem [DEPTH];
  logic [4:0]  table_link [DEPTH];
  logic [31:0] heap_ptr;
  int          slots_used;

  out_word_t   pending_words [$];
  int          errors = 0;
  int          burst_left = 0;

  // Bump allocator: align up to 4 KiB without wrap, end strictly below the limit.
  function automatic bit grab_table(input logic [31:0] bytes, output logic [31:0] base);
    logic [32:0] aligned;
    logic [33:0] end_addr;
    aligned  = ({1'b0, heap_ptr} + 33'hFFF) & ~33'hFFF;
    end_addr = {1'b0, aligned} + {17'd0, bytes[16:0]};
    base = aligned[31:0];
    if (slots_used >= TABLE_SLOTS || end_addr >= {2'b0, heap_limit_r}) return 1'b0;
    heap_ptr = end_addr[31:0];
    slots_used++;
    return 1'b1;
  endfunction

  // Follow the child of one entry, or allocate and link a new table there.
  function automatic bit step_level(input int tbl, input logic [8:0] idx,
                                    input logic [31:0] bytes, input logic [63:0] flags,
                                    output int child);
    int pos;
    int slot;
    logic [31:0] base;
    pos = tbl * ENTRIES + idx;
    if (table_link[pos] != 0) begin
      child = table_link[pos] - 1;
      return 1'b1;
    end
    slot = slots_used;
    if (!grab_table(bytes, base)) return 1'b0;
    table_mem[pos]  = {32'd0, base} | flags | BIT_PRESENT;
    table_link[pos] = 5'(slot + 1);
    child = slot;
    return 1'b1;
  endfunction

  function automatic out_word_t predict_mapping(input in_word_t w);
    out_word_t   r;
    logic [63:0] flags, word;
    logic [31:0] base;
    int          pdpt, pd, pt, pos;
    r = '0;
    flags = (w.writeable ? 64'h2 : 64'h0) | (w.kernel_only ? 64'h0 : 64'h4);
    if (w.opcode == OP_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) begin
        table_mem[i]  = '0;
        table_link[i] = '0;
      end
      heap_ptr   = heap_start_r;
      slots_used = 0;
      if (!grab_table(dir_bytes_r, base)) r.status = ST_NO_MEM;
      return r;
    end
    if (w.opcode != OP_MAP_4K && w.opcode != OP_MAP_2M) return r;
    if (slots_used == 0 ||
        !step_level(0, w.virt_page[35:27], dir_bytes_r, flags, pdpt) ||
        !step_level(pdpt, w.virt_page[26:18], dir_bytes_r, flags, pd)) begin
      r.status = ST_NO_MEM;
      return r;
    end
    if (w.opcode == OP_MAP_2M) begin
      word = ({12'd0, w.phys_frame, 12'd0} & 64'hFFFF_FFFF_FFE0_0000)
             | flags | BIT_PRESENT | BIT_LARGE;
      table_mem[pd * ENTRIES + w.virt_page[17:9]] = word;
      r.entry_written = word;
      return r;
    end
    if (!step_level(pd, w.virt_page[17:9], leaf_bytes_r, flags, pt)) begin
      r.status = ST_NO_MEM;
      return r;
    end
    pos = pt * ENTRIES + w.virt_page[8:0];
    if (table_mem[pos] != 0) begin
      r.status = ST_ALREADY;
      return r;
    end
    word = {12'd0, w.phys_frame, 12'd0} | flags | BIT_PRESENT;
    table_mem[pos] = word;
    r.entry_written = word;
    return r;
  endfunction

  // Send one word; call at a rising edge, returns at the edge that takes it.
  task automatic send_word(input in_word_t w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    pending_words.push_back(predict_mapping(w));
  endtask

  // Bursts of back-to-back words with random holes between them.
  task automatic send_paced(input in_word_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 25);
    end
    burst_left--;
    send_word(w, gap);
  endtask

  function automatic in_word_t make_word(input logic [1:0] op, input logic [8:0] i4,
                                         input logic [8:0] i3, input logic [8:0] i2,
                                         input logic [8:0] i1, input logic [39:0] pf,
                                         input logic ko, input logic wr);
    in_word_t w;
    w.opcode = op;
    w.virt_page = {i4, i3, i2, i1};
    w.phys_frame = pf;
    w.kernel_only = ko;
    w.writeable = wr;
    return w;
  endfunction

  // Hold off until every result word is in, then let the block settle.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEAP_START: heap_start_r = val;
      REG_HEAP_LIMIT: heap_limit_r = val;
      REG_DIR_BYTES:  dir_bytes_r  = {15'd0, val[16:0]};
      default:        leaf_bytes_r = {15'd0, val[16:0]};
    endcase
  endtask

  task automatic set_heap(input logic [31:0] hs, input logic [31:0] hl,
                          input logic [31:0] db, input logic [31:0] lb);
    drain_results();
    write_reg(REG_HEAP_START, hs);
    write_reg(REG_HEAP_LIMIT, hl);
    write_reg(REG_DIR_BYTES, db);
    write_reg(REG_LEAF_BYTES, lb);
  endtask

  // Check each result word in the cycle its strobe is high.
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_word.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_word.status);
          errors++;
        end
        if (out_word.entry_written !== want.entry_written) begin
          $display("%0t: entry expected %h actual %h", $time, want.entry_written,
                   out_word.entry_written);
          errors++;
        end
      end
    end
  end

  // Map with no root, unused opcode, and the clear that builds the root.
  task automatic test_no_root();
    send_word(make_word(OP_MAP_4K, 9'd1, 9'd2, 9'd3, 9'd4, 40'h12345, 1'b0, 1'b1), 0);
    send_word(make_word(OP_MAP_2M, 9'd1, 9'd2, 9'd3, 9'd4, 40'h12345, 1'b1, 1'b0), 0);
    send_word(make_word(OP_UNUSED, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, '1, 1'b1, 1'b1), 0);
    send_word(make_word(OP_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
  endtask

  // Field extremes, repeat onto an occupied leaf.
  task automatic test_basic_maps();
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd0, 9'd0, 40'h1, 1'b1, 1'b1), 1);
    send_word(make_word(OP_MAP_4K, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, '1, 1'b1, 1'b1), 0);
    send_word(make_word(OP_MAP_4K, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FE, '1, 1'b0, 1'b0), 3);
    send_word(make_word(OP_MAP_2M, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, '1, 1'b0, 1'b1), 0);
  endtask

  // Large page over an existing table and a table over a large page.
  task automatic test_overlays();
    send_word(make_word(OP_MAP_2M, 9'd0, 9'd0, 9'd0, 9'd7, 40'hA_BCDE_F123, 1'b0, 1'b1), 0);
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd0, 9'd8, 40'h55, 1'b0, 1'b1), 0);
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd0, 9'd0, 40'h66, 1'b0, 1'b1), 0);
    send_word(make_word(OP_MAP_2M, 9'd0, 9'd0, 9'd9, 9'd0, 40'h200, 1'b1, 1'b0), 2);
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd9, 9'd3, 40'h77, 1'b1, 1'b0), 0);
    send_word(make_word(OP_MAP_4K, 9'd0, 9'd0, 9'd9, 9'd3, 40'h78, 1'b1, 1'b0), 0);
    send_word(make_word(OP_UNUSED, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
  endtask

  // Heap runs out mid-walk; root fails; the widest settings.
  task automatic test_out_of_memory();
    set_heap(32'h0010_0000, 32'h0010_6001, 32'd12288, 32'd4096);
    send_word(make_word(OP_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
    send_word(make_word(OP_MAP_4K, 9'd3, 9'd4, 9'd5, 9'd6, 40'h9, 1'b0, 1'b1), 0);
    send_word(make_word(OP_MAP_2M, 9'd3, 9'd8, 9'd5, 9'd6, 40'h9, 1'b0, 1'b1), 0);
    set_heap(32'hFFFF_F001, 32'hFFFF_FFFF, 32'd65536, 32'd65536);
    send_word(make_word(OP_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
    send_word(make_word(OP_MAP_4K, 9'd3, 9'd4, 9'd5, 9'd6, 40'h9, 1'b0, 1'b1), 0);
    set_heap(32'h0, 32'h0, 32'd4096, 32'd4096);
    send_word(make_word(OP_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, '0, 1'b0, 1'b0), 0);
  endtask

  function automatic logic [8:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return 9'h1FF;
      1:       return 9'd0;
      2:       return 9'($urandom);
      default: return 9'($urandom_range(1, 3));
    endcase
  endfunction

  // Random phases: each picks a heap setup, clears, then streams maps mixed with a few clears and unused opcodes.
  task automatic test_random_phases();
    int sent;
    int pick;
    in_word_t w;
    sent = 0;
    for (int ph = 0; sent < N_RANDOM; ph++) begin
      case (ph % 6)
        0: set_heap(32'h0010_0000, 32'h0100_0000, 32'd12288, 32'd4096);
        1: set_heap(32'h0, 32'hFFFF_FFFF, 32'd4096, 32'd4096);
        2: set_heap(32'h0001_2345, 32'h0003_8000, 32'd4096, 32'd65536);
        3: set_heap(32'h0, 32'hFFFF_FFFF, 32'd65536, 32'd65536);
        4: set_heap($urandom, $urandom, $urandom_range(4096, 65536),
                    $urandom_range(4096, 65536));
        default: set_heap($urandom_range(0, 32'h10_0000), $urandom_range(32'h8000, 32'h40_0000),
                          $urandom_range(4096, 20000), $urandom_range(4096, 20000));
      endcase
      send_word(make_word(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0, 1'b0), 0);
      for (int k = 0; k < 130 && sent < N_RANDOM; k++) begin
        pick = $urandom_range(0, 99);
        w = make_word(OP_MAP_4K, pick_index(), pick_index(), pick_index(),
                      ($urandom_range(0, 2) == 0) ? pick_index() : 9'($urandom),
                      {$urandom, $urandom}, 1'($urandom), 1'($urandom));
        if (pick < 35) w.opcode = OP_MAP_2M;
        else if (pick < 37) w.opcode = OP_CLEAR;
        else if (pick < 40) w.opcode = OP_UNUSED;
        send_paced(w);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_HEAP_START;
    cfg_wdata = '0;
    heap_start_r = 32'h0010_0000;
    heap_limit_r = 32'h0100_0000;
    dir_bytes_r  = 32'd12288;
    leaf_bytes_r = 32'd4096;
    heap_ptr     = heap_start_r;
    slots_used   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_root();
    test_basic_maps();
    test_overlays();
    test_out_of_memory();
    test_random_phases();
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Ceiling on run time: clears dominate, as each sweeps the whole store.
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end
endmodule
